// ===== rtl/edd_pkg.sv =====
// Shared types and constants for the error diffusion dither core.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package edd_pkg;

  // Default build parameters.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int ERR_FRAC_DEF  = 8;

  // Pixel channel width.
  localparam int PIX_W = 8;

  // Configuration register map.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_BITS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 1'd1;
  localparam int LEVEL_BITS_W = 4;
  localparam int LINE_WIDTH_W = 12;
  localparam logic [LEVEL_BITS_W-1:0] LEVEL_BITS_RST = 4'd1;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd640;
  localparam logic [LEVEL_BITS_W-1:0] LEVEL_BITS_MAX = 4'd8;

  // Division by 255: q = (n * 65793) >> 24, low by at most one.
  localparam int N255_W          = 18;
  localparam int DIV255_RECIP_W  = 17;
  localparam logic [DIV255_RECIP_W-1:0] DIV255_RECIP = 17'd65793;
  localparam int DIV255_SHIFT    = 24;
  localparam int DIV255_PROD_W   = N255_W + DIV255_RECIP_W;
  localparam int DIV255_Q_W      = DIV255_PROD_W - DIV255_SHIFT;

  // Quantized level: magnitude up to 770.
  localparam int LVL_MAG_W = 10;
  localparam int LVL_W     = LVL_MAG_W + 1;

  // Floyd-Steinberg weights in sixteenths.
  localparam logic [2:0] SHARE_RIGHT      = 3'd7;
  localparam logic [2:0] SHARE_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] SHARE_DOWN       = 3'd5;
  localparam logic [2:0] SHARE_DOWN_RIGHT = 3'd1;

  // Controller to datapath commands: one step of the per-pixel sequence each.
  typedef struct packed {
    logic accept;
    logic rd;
    logic sum;
    logic lvl1;
    logic lvl2;
    logic err1;
    logic err2;
    logic err3;
    logic diff;
    logic tail;
    logic out_load;
  } edd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic row_end;
  } edd_sts_t;

endpackage

// ===== rtl/edd_if.sv =====
// Valid/ready channel interfaces for pixel words in and dithered words out.
// Depends on edd_pkg.
interface edd_in_if;
  import edd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface edd_out_if;
  import edd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/edd_chan.sv =====
// One color channel: quantizer, error computation and error diffusion state.
// Steps are enabled by controller commands. Depends on edd_pkg.
module edd_chan #(
  parameter int ERR_FRAC_BITS = edd_pkg::ERR_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  edd_pkg::edd_cmd_t          cmd,
  input  logic                       restart,
  input  logic                       first_row,
  input  logic                       row_end,
  input  logic [7:0]                 pix,
  input  logic [ERR_FRAC_BITS+9:0]   rd_err,
  input  logic [3:0]                 bits,
  input  logic [7:0]                 maxl,
  input  logic [ERR_FRAC_BITS+12:0]  recip,
  output logic [7:0]                 pix_out,
  output logic [ERR_FRAC_BITS+9:0]   wr_main,
  output logic [ERR_FRAC_BITS+9:0]   pend_down
);
  import edd_pkg::*;

  localparam int F  = ERR_FRAC_BITS;
  localparam int EW = F + 10;
  localparam int VW = F + 11;
  localparam int MW = F + 10;
  localparam int RF = F + 13;
  localparam int NW = VW + 9;
  localparam int SW = EW + 2;
  localparam logic signed [EW-1:0] ERR_HI = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] ERR_LO = {1'b1, {(EW-1){1'b0}}};

  function automatic logic signed [EW-1:0] sat_err(input logic signed [SW-1:0] x);
    if (x > SW'(ERR_HI)) return ERR_HI;
    if (x < SW'(ERR_LO)) return ERR_LO;
    return EW'(x);
  endfunction

  // Share of an error in sixteenths, truncated toward zero.
  function automatic logic signed [EW-1:0] share(input logic signed [EW-1:0] e,
                                                 input logic [2:0] k);
    logic signed [EW+3:0] t;
    logic signed [EW+3:0] tb;
    t  = (EW+4)'(e) * (EW+4)'($signed({1'b0, k}));
    tb = t + (t[EW+3] ? (EW+4)'(15) : (EW+4)'(0));
    return EW'(tb >>> 4);
  endfunction

  logic signed [VW-1:0]       v_r;
  logic [DIV255_PROD_W-1:0]   prod_r;
  logic signed [LVL_W-1:0]    lvl_r;
  logic                       lvl_neg_r;
  logic                       lvl_full_r;
  logic [15:0]                p_r;
  logic [MW-1:0]              absn_r;
  logic                       negn_r;
  logic [16+RF-1:0]           prodo_r;
  logic [MW+RF-1:0]           prode_r;
  logic [7:0]                 o_r;
  logic signed [EW-1:0]       e_r;
  logic signed [EW-1:0]       rc_r;
  logic signed [EW-1:0]       pend0_r;
  logic signed [EW-1:0]       pend1_r;

  logic signed [EW-1:0]       e_sum;
  logic signed [VW-1:0]       v_nxt;
  logic [MW-1:0]              absv;
  logic [MW+7:0]              absv_sh;
  logic [N255_W-1:0]          n255;
  logic [DIV255_Q_W-1:0]      q_est;
  logic [N255_W:0]            rem255;
  logic [LVL_MAG_W-1:0]       lvl_mag;
  logic signed [LVL_W-1:0]    lvl_u;
  logic signed [LVL_W-1:0]    lvl_nxt;
  logic                       lvl_neg;
  logic [LVL_MAG_W-1:0]       mag;
  logic                       lvl_full;
  logic signed [NW-1:0]       vm;
  logic signed [NW-1:0]       lm;
  logic signed [NW-1:0]       nn;
  logic [15:0]                qo;
  logic [23:0]                ro;
  logic [7:0]                 qo_c;
  logic [7:0]                 o_nxt;
  logic [MW-1:0]              qe;
  logic [MW+7:0]              re;
  logic [MW-1:0]              qe_c;
  logic signed [SW-1:0]       e_wide;
  logic signed [EW-1:0]       sh7;
  logic signed [EW-1:0]       sh3;
  logic signed [EW-1:0]       sh5;
  logic signed [EW-1:0]       sh1;
  logic signed [EW-1:0]       pend1_n;
  logic signed [EW-1:0]       wr_main_s;

  always_comb begin
    // Incoming error: right carry plus the stored term from the row above.
    e_sum = sat_err(SW'(rc_r) + (first_row ? SW'(0) : SW'($signed(rd_err))));
    v_nxt = $signed({3'b000, pix, {F{1'b0}}}) + VW'(e_sum);

    // level = trunc(V * 2^bits / (255 << F)), done on the magnitude.
    absv    = v_r[VW-1] ? MW'(-v_r) : MW'(v_r);
    absv_sh = (MW+8)'(absv) << bits;
    n255    = absv_sh[MW+7:F];
    q_est   = prod_r[DIV255_SHIFT +: DIV255_Q_W];
    rem255  = (N255_W+1)'(n255) - (N255_W+1)'(q_est) * (N255_W+1)'(255);
    lvl_mag = LVL_MAG_W'(q_est) + LVL_MAG_W'(rem255 >= (N255_W+1)'(255));
    lvl_u   = $signed({1'b0, lvl_mag});
    lvl_nxt = v_r[VW-1] ? -lvl_u : lvl_u;

    // Output scaling and quantization error numerator.
    lvl_neg  = lvl_r[LVL_W-1];
    mag      = lvl_neg ? LVL_MAG_W'(-lvl_r) : LVL_MAG_W'(lvl_r);
    lvl_full = !lvl_neg && (mag >= LVL_MAG_W'(maxl));
    vm       = NW'(v_r) * NW'($signed({1'b0, maxl}));
    lm       = NW'(lvl_r) * NW'(255);
    nn       = vm - (lm <<< F);

    // Divisions by max via reciprocal, then one correction step each.
    qo    = prodo_r[16+RF-1:RF];
    ro    = 24'(p_r) - 24'(qo) * 24'(maxl);
    qo_c  = qo[7:0] + 8'(ro >= 24'(maxl));
    o_nxt = lvl_neg_r ? 8'd0 : (lvl_full_r ? 8'hFF : qo_c);

    qe     = prode_r[MW+RF-1:RF];
    re     = (MW+8)'(absn_r) - (MW+8)'(qe) * (MW+8)'(maxl);
    qe_c   = qe + MW'(re >= (MW+8)'(maxl));
    e_wide = negn_r ? -$signed(SW'(qe_c)) : $signed(SW'(qe_c));

    sh7       = share(e_r, SHARE_RIGHT);
    sh3       = share(e_r, SHARE_DOWN_LEFT);
    sh5       = share(e_r, SHARE_DOWN);
    sh1       = share(e_r, SHARE_DOWN_RIGHT);
    wr_main_s = sat_err(SW'(pend0_r) + SW'(sh3));
    pend1_n   = sat_err(SW'(pend1_r) + SW'(sh5));
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      v_r <= v_nxt;
    end
    if (cmd.lvl1) begin
      prod_r <= DIV255_PROD_W'(n255) * DIV255_PROD_W'(DIV255_RECIP);
    end
    if (cmd.lvl2) begin
      lvl_r <= lvl_nxt;
    end
    if (cmd.err1) begin
      lvl_neg_r  <= lvl_neg;
      lvl_full_r <= lvl_full;
      p_r        <= 16'(mag[7:0]) * 16'(255);
      negn_r     <= nn[NW-1];
      absn_r     <= nn[NW-1] ? MW'(-nn) : MW'(nn);
    end
    if (cmd.err2) begin
      prodo_r <= (16+RF)'(p_r) * (16+RF)'(recip);
      prode_r <= (MW+RF)'(absn_r) * (MW+RF)'(recip);
    end
    if (cmd.err3) begin
      o_r <= o_nxt;
      e_r <= sat_err(e_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r    <= '0;
      pend0_r <= '0;
      pend1_r <= '0;
    end else if (restart || cmd.tail) begin
      rc_r    <= '0;
      pend0_r <= '0;
      pend1_r <= '0;
    end else if (cmd.diff) begin
      if (row_end) begin
        pend1_r <= pend1_n;
      end else begin
        pend0_r <= pend1_n;
        pend1_r <= sh1;
        rc_r    <= sh7;
      end
    end
  end

  assign pix_out   = o_r;
  assign wr_main   = wr_main_s;
  assign pend_down = pend1_r;

endmodule

// ===== rtl/edd_datapath.sv =====
// Datapath: configuration registers, column tracking, line store of next-row errors,
// three channel units and the output data register. Depends on edd_pkg, edd_chan.
module edd_datapath #(
  parameter int MAX_WIDTH     = edd_pkg::MAX_WIDTH_DEF,
  parameter int ERR_FRAC_BITS = edd_pkg::ERR_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  edd_pkg::edd_cmd_t               cmd,
  output edd_pkg::edd_sts_t               sts,
  input  logic [edd_pkg::PIX_W-1:0]       red_in,
  input  logic [edd_pkg::PIX_W-1:0]       green_in,
  input  logic [edd_pkg::PIX_W-1:0]       blue_in,
  input  logic                            frame_start,
  input  logic                            cfg_we,
  input  logic [edd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [edd_pkg::PIX_W-1:0]       red_out,
  output logic [edd_pkg::PIX_W-1:0]       green_out,
  output logic [edd_pkg::PIX_W-1:0]       blue_out
);
  import edd_pkg::*;

  localparam int EW  = ERR_FRAC_BITS + 10;
  localparam int RF  = ERR_FRAC_BITS + 13;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > LINE_WIDTH_W) ? WW0 : LINE_WIDTH_W;
  localparam int DW  = 3 * EW;

  // floor(2^RF / (2^b - 1)) as a repeating bit pattern (one low for b = 1).
  function automatic logic [RF-1:0] recip_pat(input int b);
    logic [RF-1:0] r;
    r = '0;
    for (int k = 1; k <= RF; k++) begin
      if (k * b <= RF) r[RF - k * b] = 1'b1;
    end
    return r;
  endfunction

  logic [LEVEL_BITS_W-1:0] level_bits_r;
  logic [LINE_WIDTH_W-1:0] line_width_r;
  logic [AW-1:0]           column_r;
  logic                    first_row_r;
  logic [PIX_W-1:0]        pix_r [3];
  logic [DW-1:0]           rd_r;
  logic [DW-1:0]           mem [MAX_WIDTH];
  logic [PIX_W-1:0]        out_r [3];

  logic [LEVEL_BITS_W-1:0] bits_eff;
  logic [7:0]              maxl;
  logic [RF-1:0]           recip;
  logic [WW-1:0]           width_ext;
  logic [WW-1:0]           width_eff;
  logic [WW-1:0]           col_p1;
  logic                    row_end;
  logic                    restart;
  logic [PIX_W-1:0]        pix_o [3];
  logic [EW-1:0]           wr_main [3];
  logic [EW-1:0]           pend_down [3];
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [DW-1:0]           mem_wd;

  always_comb begin
    bits_eff = level_bits_r;
    if (level_bits_r == '0) bits_eff = LEVEL_BITS_W'(1);
    if (level_bits_r > LEVEL_BITS_MAX) bits_eff = LEVEL_BITS_MAX;
    maxl = 8'hFF >> (LEVEL_BITS_MAX - bits_eff);
    unique case (bits_eff)
      4'd1:    recip = recip_pat(1);
      4'd2:    recip = recip_pat(2);
      4'd3:    recip = recip_pat(3);
      4'd4:    recip = recip_pat(4);
      4'd5:    recip = recip_pat(5);
      4'd6:    recip = recip_pat(6);
      4'd7:    recip = recip_pat(7);
      default: recip = recip_pat(8);
    endcase

    width_ext = WW'(line_width_r);
    width_eff = width_ext;
    if (width_ext == '0) width_eff = WW'(1);
    if (width_ext > WW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
    col_p1  = WW'(column_r) + WW'(1);
    row_end = (col_p1 >= width_eff);
    restart = cmd.accept && frame_start;

    // Down-left sum goes to the previous column; at row end the down sum goes
    // to the current column in a second write, on the tail command.
    mem_we = 1'b0;
    mem_wa = column_r - AW'(1);
    mem_wd = {wr_main[2], wr_main[1], wr_main[0]};
    if (cmd.diff && (column_r != '0)) mem_we = 1'b1;
    if (cmd.tail) begin
      mem_we = 1'b1;
      mem_wa = column_r;
      mem_wd = {pend_down[2], pend_down[1], pend_down[0]};
    end
  end

  assign sts.row_end = row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r <= LEVEL_BITS_RST;
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL_BITS: level_bits_r <= cfg_wdata[LEVEL_BITS_W-1:0];
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (restart) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (cmd.tail) begin
      column_r    <= '0;
      first_row_r <= 1'b0;
    end else if (cmd.diff && !row_end) begin
      column_r <= column_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r[0] <= red_in;
      pix_r[1] <= green_in;
      pix_r[2] <= blue_in;
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      rd_r <= mem[column_r];
    end
    if (cmd.out_load) begin
      out_r <= pix_o;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    edd_chan #(
      .ERR_FRAC_BITS(ERR_FRAC_BITS)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .restart   (restart),
      .first_row (first_row_r),
      .row_end   (row_end),
      .pix       (pix_r[ch]),
      .rd_err    (rd_r[ch*EW +: EW]),
      .bits      (bits_eff),
      .maxl      (maxl),
      .recip     (recip),
      .pix_out   (pix_o[ch]),
      .wr_main   (wr_main[ch]),
      .pend_down (pend_down[ch])
    );
  end

  assign red_out   = out_r[0];
  assign green_out = out_r[1];
  assign blue_out  = out_r[2];

endmodule

// ===== rtl/edd_ctrl.sv =====
// Controller: steps each accepted pixel word through the datapath sequence and
// owns the output valid flag. Depends on edd_pkg.
module edd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  edd_pkg::edd_sts_t sts,
  output edd_pkg::edd_cmd_t cmd
);
  import edd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_LVL1,
    S_LVL2,
    S_ERR1,
    S_ERR2,
    S_ERR3,
    S_DIFF,
    S_TAIL,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.rd       = (state_r == S_READ);
    cmd.sum      = (state_r == S_SUM);
    cmd.lvl1     = (state_r == S_LVL1);
    cmd.lvl2     = (state_r == S_LVL2);
    cmd.err1     = (state_r == S_ERR1);
    cmd.err2     = (state_r == S_ERR2);
    cmd.err3     = (state_r == S_ERR3);
    cmd.diff     = (state_r == S_DIFF);
    cmd.tail     = (state_r == S_TAIL);
    cmd.out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_LVL1;
      S_LVL1: state_nxt = S_LVL2;
      S_LVL2: state_nxt = S_ERR1;
      S_ERR1: state_nxt = S_ERR2;
      S_ERR2: state_nxt = S_ERR3;
      S_ERR3: state_nxt = S_DIFF;
      S_DIFF: state_nxt = sts.row_end ? S_TAIL : S_OUT;
      S_TAIL: state_nxt = S_OUT;
      S_OUT:  if (cmd.out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/error_diffusion_dither_core.sv =====
// Floyd-Steinberg error diffusion dither for RGB pixels in raster order. The
// controller steps each accepted word through the read, sum, level, error and
// diffusion steps, a tail step on the last pixel of a row, and the output load;
// a word is taken again once the previous result sits in the output register,
// which holds it until the sink takes it.
// Raise frame_start on the first pixel of each frame; the first row then reads no
// errors from the line store. Write level_bits and line_width only while idle.
// Depends on edd_pkg, edd_if, edd_ctrl and edd_datapath.
module error_diffusion_dither_core #(
  parameter int MAX_WIDTH     = edd_pkg::MAX_WIDTH_DEF,
  parameter int ERR_FRAC_BITS = edd_pkg::ERR_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  edd_in_if.sink                          in_ch,
  edd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [edd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import edd_pkg::*;

  edd_cmd_t cmd;
  edd_sts_t sts;

  edd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edd_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .ERR_FRAC_BITS (ERR_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .red_in      (in_ch.red_in),
    .green_in    (in_ch.green_in),
    .blue_in     (in_ch.blue_in),
    .frame_start (in_ch.frame_start),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .red_out     (out_ch.red_out),
    .green_out   (out_ch.green_out),
    .blue_out    (out_ch.blue_out)
  );

endmodule
